[hdl/xxh32_pkg.sv]
`default_nettype none

package xxh32_pkg;

    localparam logic [31:0] PRIME1 = 32'h9E3779B1;
    localparam logic [31:0] PRIME2 = 32'h85EBCA77;
    localparam logic [31:0] PRIME3 = 32'hC2B2AE3D;
    localparam logic [31:0] PRIME4 = 32'h27D4EB2F;
    localparam logic [31:0] PRIME5 = 32'h165667B1;

    // PRIME1 + PRIME2 modulo 2^32, start value of lane 0
    localparam logic [31:0] LANE0_OFFSET = 32'h24234428;

    localparam int ROT_STRIPE = 13;
    localparam int ROT_WORD   = 17;
    localparam int ROT_BYTE   = 11;
    localparam int SHR_AV1    = 15;
    localparam int SHR_AV2    = 13;
    localparam int SHR_AV3    = 16;

    localparam int PADDR_W = 3;

    // register index carried in paddr[2]
    localparam logic REG_SEED = 1'b0;

    // constant rotate left, amount in 1..31
    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

endpackage

`default_nettype wire

[hdl/xxhash32_stream_hasher.sv]
// Flow: an item without the last marker is taken in S_IDLE; when its byte completes a 16-byte
//   stripe, the 4 lanes are updated in 3 steps each through the shared 32x32 multiplier.
// An item with the last marker then adds lane merge and length, a step sequence per leftover
//   word or byte (each needs two passes through the multiplier), and mix and output; one item
//   is in work at a time, the finished hash waits in m_tdata, and the output step stalls while
//   an earlier hash still waits there.
// Reset (aresetn low at a clock edge) clears the seed, the message state and m_tvalid.
`default_nettype none

module xxhash32_stream_hasher (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // APB configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [xxh32_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    // input items
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,  // [7:0] data_byte
    input  wire logic [0:0]                     s_tuser,  // [0] byte_valid
    input  wire logic                           s_tlast,  // last_item
    // result items
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [31:0]                    m_tdata   // [31:0] hash_value
);

    import xxh32_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LANE_MULW,
        S_LANE_ADD,
        S_LANE_MULP,
        S_FIN_START,
        S_FIN_MERGE,
        S_FIN_LEN,
        S_TAIL_SEL,
        S_W_MUL,
        S_W_ADD,
        S_W_MUL2,
        S_B_MUL,
        S_B_ADD,
        S_B_MUL2,
        S_AV_X1,
        S_AV_M1,
        S_AV_X2,
        S_AV_M2,
        S_OUT
    } state_t;

    state_t      state_reg;
    logic [31:0] seed_reg;
    logic [31:0] lane_reg [4];
    logic [31:0] stripe_reg [4];
    logic [3:0]  fill_reg;
    logic [31:0] len_reg;
    logic        seen_reg;
    logic        last_pend_reg;
    logic [1:0]  k_reg;
    logic [3:0]  pos_reg;
    logic [31:0] acc_reg;
    logic [31:0] prod_reg;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    logic        in_acc;
    logic        cfg_wr;
    logic [1:0]  word_idx;
    logic [31:0] word_sel;
    logic [7:0]  byte_sel;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_out;
    logic [31:0] lane_rot;
    logic        out_free;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_SEED) ? seed_reg : 32'd0;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign word_idx = (state_reg == S_LANE_MULW) ? k_reg : pos_reg[3:2];
    assign word_sel = stripe_reg[word_idx];
    assign byte_sel = word_sel[{pos_reg[1:0], 3'b000} +: 8];

    // shared multiplier operand select
    always_comb begin
        mul_a = acc_reg;
        mul_b = PRIME1;
        unique case (state_reg)
            S_LANE_MULW: begin
                mul_a = word_sel;
                mul_b = PRIME2;
            end
            S_W_MUL: begin
                mul_a = word_sel;
                mul_b = PRIME3;
            end
            S_W_MUL2: mul_b = PRIME4;
            S_B_MUL: begin
                mul_a = {24'd0, byte_sel};
                mul_b = PRIME5;
            end
            S_AV_M1: mul_b = PRIME2;
            S_AV_M2: mul_b = PRIME3;
            default: begin
                mul_a = acc_reg;
                mul_b = PRIME1;
            end
        endcase
    end

    assign mul_out = mul_a * mul_b;

    always_comb begin
        unique case (k_reg)
            2'd0:    lane_rot = rotl(lane_reg[0], 1);
            2'd1:    lane_rot = rotl(lane_reg[1], 7);
            2'd2:    lane_rot = rotl(lane_reg[2], 12);
            default: lane_rot = rotl(lane_reg[3], 18);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            seed_reg      <= 32'd0;
            fill_reg      <= 4'd0;
            len_reg       <= 32'd0;
            seen_reg      <= 1'b0;
            last_pend_reg <= 1'b0;
            k_reg         <= 2'd0;
            pos_reg       <= 4'd0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr && paddr[2] == REG_SEED) begin
                seed_reg <= pwdata;
            end
            // the output state refills the slot itself
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        last_pend_reg <= s_tlast;
                        if (s_tuser[0]) begin
                            stripe_reg[fill_reg[3:2]][{fill_reg[1:0], 3'b000} +: 8] <= s_tdata;
                            len_reg <= len_reg + 32'd1;
                            if (fill_reg == 4'hF) begin
                                // stripe complete: load lanes on the first one
                                if (!seen_reg) begin
                                    lane_reg[0] <= seed_reg + LANE0_OFFSET;
                                    lane_reg[1] <= seed_reg + PRIME2;
                                    lane_reg[2] <= seed_reg;
                                    lane_reg[3] <= seed_reg - PRIME1;
                                end
                                seen_reg  <= 1'b1;
                                fill_reg  <= 4'd0;
                                k_reg     <= 2'd0;
                                state_reg <= S_LANE_MULW;
                            end else begin
                                fill_reg <= fill_reg + 4'd1;
                                if (s_tlast) begin
                                    state_reg <= S_FIN_START;
                                end
                            end
                        end else if (s_tlast) begin
                            state_reg <= S_FIN_START;
                        end
                    end
                end
                S_LANE_MULW: begin
                    prod_reg  <= mul_out;
                    state_reg <= S_LANE_ADD;
                end
                S_LANE_ADD: begin
                    acc_reg   <= rotl(lane_reg[k_reg] + prod_reg, ROT_STRIPE);
                    state_reg <= S_LANE_MULP;
                end
                S_LANE_MULP: begin
                    lane_reg[k_reg] <= mul_out;
                    k_reg           <= k_reg + 2'd1;
                    if (k_reg == 2'd3) begin
                        state_reg <= last_pend_reg ? S_FIN_START : S_IDLE;
                    end else begin
                        state_reg <= S_LANE_MULW;
                    end
                end
                S_FIN_START: begin
                    k_reg <= 2'd1;
                    if (seen_reg) begin
                        acc_reg   <= rotl(lane_reg[0], 1);
                        state_reg <= S_FIN_MERGE;
                    end else begin
                        acc_reg   <= seed_reg + PRIME5;
                        state_reg <= S_FIN_LEN;
                    end
                end
                S_FIN_MERGE: begin
                    acc_reg <= acc_reg + lane_rot;
                    k_reg   <= k_reg + 2'd1;
                    if (k_reg == 2'd3) begin
                        state_reg <= S_FIN_LEN;
                    end
                end
                S_FIN_LEN: begin
                    acc_reg   <= acc_reg + len_reg;
                    pos_reg   <= 4'd0;
                    state_reg <= S_TAIL_SEL;
                end
                S_TAIL_SEL: begin
                    priority if ({1'b0, pos_reg} + 5'd4 <= {1'b0, fill_reg}) begin
                        state_reg <= S_W_MUL;
                    end else if (pos_reg < fill_reg) begin
                        state_reg <= S_B_MUL;
                    end else begin
                        state_reg <= S_AV_X1;
                    end
                end
                S_W_MUL: begin
                    prod_reg  <= mul_out;
                    state_reg <= S_W_ADD;
                end
                S_W_ADD: begin
                    acc_reg   <= rotl(acc_reg + prod_reg, ROT_WORD);
                    state_reg <= S_W_MUL2;
                end
                S_W_MUL2: begin
                    acc_reg   <= mul_out;
                    pos_reg   <= pos_reg + 4'd4;
                    state_reg <= S_TAIL_SEL;
                end
                S_B_MUL: begin
                    prod_reg  <= mul_out;
                    state_reg <= S_B_ADD;
                end
                S_B_ADD: begin
                    acc_reg   <= rotl(acc_reg + prod_reg, ROT_BYTE);
                    state_reg <= S_B_MUL2;
                end
                S_B_MUL2: begin
                    acc_reg   <= mul_out;
                    pos_reg   <= pos_reg + 4'd1;
                    state_reg <= S_TAIL_SEL;
                end
                S_AV_X1: begin
                    acc_reg   <= acc_reg ^ (acc_reg >> SHR_AV1);
                    state_reg <= S_AV_M1;
                end
                S_AV_M1: begin
                    acc_reg   <= mul_out;
                    state_reg <= S_AV_X2;
                end
                S_AV_X2: begin
                    acc_reg   <= acc_reg ^ (acc_reg >> SHR_AV2);
                    state_reg <= S_AV_M2;
                end
                S_AV_M2: begin
                    acc_reg   <= mul_out;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output slot drains, then start a new message
                    if (out_free) begin
                        m_tdata_reg  <= acc_reg ^ (acc_reg >> SHR_AV3);
                        m_tvalid_reg <= 1'b1;
                        fill_reg     <= 4'd0;
                        len_reg      <= 32'd0;
                        seen_reg     <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input accepted right after a last item");

    a_msg_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> (len_reg == 32'd0 && !seen_reg && fill_reg == 4'd0))
        else $error("message state not cleared when hash issued");

    a_lane_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LANE_MULW) |-> (fill_reg == 4'd0 && seen_reg))
        else $error("lane update without a completed stripe");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && m_tvalid && !m_tready) |=> (state_reg == S_OUT))
        else $error("hash overwrote a waiting result");

endmodule

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;
    import xxh32_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 40;
    localparam int ITEM_TARGET    = 550;
    localparam int PHASE_ITEMS    = 110;

    // expected-hash tracker: mirrors the hasher state and queues the digests it predicts
    class xxh32_scoreboard;
        logic [31:0] seed_reg;
        logic [31:0] lane [4];
        logic [7:0]  stripe [16];
        int unsigned fill;
        logic [31:0] msg_len;
        bit          seen_full;
        logic [31:0] hash_queue [$];
        int          mismatches;
        int          errors;
        int          hashes_seen;

        function new();
            seed_reg = '0;
            foreach (stripe[i]) stripe[i] = '0;
            load_lanes();
            restart();
            mismatches  = 0;
            errors      = 0;
            hashes_seen = 0;
        endfunction

        static function logic [31:0] rol(input logic [31:0] x, input int r);
            return (r == 0) ? x : ((x << r) | (x >> (32 - r)));
        endfunction

        function logic [31:0] word_at(input int pos);
            return {stripe[pos + 3], stripe[pos + 2], stripe[pos + 1], stripe[pos]};
        endfunction

        function void load_lanes();
            lane[0] = seed_reg + PRIME1 + PRIME2;
            lane[1] = seed_reg + PRIME2;
            lane[2] = seed_reg;
            lane[3] = seed_reg - PRIME1;
        endfunction

        function void restart();
            load_lanes();
            fill      = 0;
            msg_len   = '0;
            seen_full = 1'b0;
        endfunction

        function void absorb_stripe();
            // lanes pick up the seed only when the first stripe of a message completes
            if (!seen_full) load_lanes();
            for (int k = 0; k < 4; k++)
                lane[k] = rol(lane[k] + word_at(4 * k) * PRIME2, ROT_STRIPE) * PRIME1;
            seen_full = 1'b1;
        endfunction

        function logic [31:0] digest();
            logic [31:0] h;
            int pos;
            pos = 0;
            if (seen_full)
                h = rol(lane[0], 1) + rol(lane[1], 7) + rol(lane[2], 12) + rol(lane[3], 18);
            else
                h = seed_reg + PRIME5;
            h += msg_len;
            for (; pos + 4 <= fill; pos += 4)
                h = rol(h + word_at(pos) * PRIME3, ROT_WORD) * PRIME4;
            for (; pos < fill; pos++)
                h = rol(h + {24'd0, stripe[pos]} * PRIME5, ROT_BYTE) * PRIME1;
            h ^= h >> SHR_AV1;
            h *= PRIME2;
            h ^= h >> SHR_AV2;
            h *= PRIME3;
            h ^= h >> SHR_AV3;
            return h;
        endfunction

        function void note_input(input logic [7:0] b, input logic v, input logic l);
            if (v) begin
                stripe[fill] = b;
                msg_len += 1;
                if (fill == 15) begin
                    absorb_stripe();
                    fill = 0;
                end else begin
                    fill++;
                end
            end
            if (l) begin
                hash_queue.push_back(digest());
                restart();
            end
        endfunction

        function void check_result(input logic [31:0] got);
            logic [31:0] want;
            hashes_seen++;
            if (hash_queue.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= 10) $display("unexpected hash %08h", got);
                return;
            end
            want = hash_queue.pop_front();
            if (got !== want) begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("hash mismatch: expected %08h, got %08h", want, got);
            end
        endfunction

        function int pending();
            return hash_queue.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;  // [7:0] data_byte
    logic [0:0]           s_tuser;  // [0] byte_valid
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;  // [31:0] hash_value

    xxh32_scoreboard sb;
    bit steady;
    bit hold_req;
    int item_count;
    int quiet_cycles;

    xxhash32_stream_hasher u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 16);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic v, input logic l);
        while (!steady && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= v;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(b, v, l);
        if (v || l) item_count++;
        @(negedge aclk);
    endtask

    // stop offering items, let every expected hash arrive and the engine go quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SEED, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.seed_reg = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one message of n bytes; split_at >= 0 rewrites the seed after that byte
    task automatic send_message(input int n, input bit end_on_byte, input int split_at);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, end_on_byte && (i == n - 1));
            if (i == split_at) begin
                drain();
                write_seed($urandom);
            end
        end
        if (!end_on_byte || n == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(12);
        if (r < 92) return $urandom_range(40, 13);
        return $urandom_range(80, 41);
    endfunction

    initial begin
        int phase;
        int budget_end;
        int n;
        bit split_done;
        sb           = new();
        steady       = 1'b0;
        hold_req     = 1'b0;
        item_count   = 0;
        quiet_cycles = 0;
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        s_tlast  <= 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty message, idle item, one 0xFF byte, one all-zero word, exact stripe
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        for (int i = 0; i < 4; i++) send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        for (int i = 0; i < 16; i++) send_item(8'(i * 17), 1'b1, i == 15);

        phase = 0;
        while (item_count < ITEM_TARGET) begin
            drain();
            case (phase)
                0:       write_seed(32'hFFFF_FFFF);
                2:       write_seed(32'h0000_0000);
                default: write_seed($urandom);
            endcase
            steady     = (phase == 2);
            hold_req   = (phase == 3);
            split_done = (phase % 2 == 0);
            budget_end = item_count + PHASE_ITEMS;
            while (item_count < budget_end) begin
                n = pick_length();
                if (!split_done && n >= 2 && $urandom_range(3) == 0) begin
                    send_message(n, 1'($urandom_range(1)), int'($urandom_range(n - 2)));
                    split_done = 1'b1;
                end else begin
                    send_message(n, 1'($urandom_range(1)), -1);
                end
            end
            phase++;
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
